// ===== rtl/core/utrb_pkg.sv =====
`default_nettype none

package utrb_pkg;

  // Default number of entries in each ring
  localparam int unsigned RING_DEPTH_DEF = 8;

  localparam int unsigned KIND_W = 3;
  localparam int unsigned BYTE_W = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT_TX   = 3'd0,
    KIND_GET_RX   = 3'd1,
    KIND_TX_READY = 3'd2,
    KIND_RX_BYTE  = 3'd3,
    KIND_FLUSH_RX = 3'd4,
    KIND_FLUSH_TX = 3'd5
  } kind_e;

  // One operation on a ring; at most one of push and pop is set per item
  typedef struct packed {
    logic push;   // write at write pointer; when full, also drops the oldest entry
    logic pop;    // read at read pointer
    logic clear;  // empty the ring
  } ring_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/uart_tx_rx_ring_buffers.sv =====
`default_nettype none

// Transmit and receive byte rings between software and a UART.
// Input channel (in_valid_i / in_stall_o) carries one item: kind_i selects
// put tx byte, get rx byte, transmitter ready, byte received, flush rx or
// flush tx; data_in_i is the byte for put and byte received.
// Output channel (out_valid_o / out_stall_i) returns one result per item:
// ok, the byte read or sent, the overwrite flag, both ring levels and the
// transmit interrupt enable as they stand after the item.
// The item is decoded against the ring pointers and counts; these update at
// the accepting edge with the result register and the registered ring read
// port, and the result is valid from that edge. Throughput is one item
// per cycle unless the receiver stalls, set by the single result register.
// If the receiver stalls, the result holds and in_stall_o rises for as long
// as the held result is not taken; an item is still taken in the cycle the
// result leaves.
// Reset empties both rings, clears the interrupt enable and drops
// out_valid_o. Ring contents are not cleared.
module uart_tx_rx_ring_buffers #(
  parameter int unsigned RING_DEPTH = utrb_pkg::RING_DEPTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [utrb_pkg::KIND_W-1:0]         kind_i,
  input  wire logic [utrb_pkg::BYTE_W-1:0]         data_in_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     ok_o,
  output logic      [utrb_pkg::BYTE_W-1:0]         data_out_o,
  output logic                                     overwrote_o,
  output logic      [$clog2(RING_DEPTH+1)-1:0]     tx_level_o,
  output logic      [$clog2(RING_DEPTH+1)-1:0]     rx_level_o,
  output logic                                     tx_irq_enable_o
);

  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

  utrb_pkg::ring_cmd_t         tx_cmd, rx_cmd;
  logic [CNT_W-1:0]            tx_fill, rx_fill;
  logic [utrb_pkg::BYTE_W-1:0] tx_rd_data, rx_rd_data;
  logic                        accept;
  logic                        tx_full, tx_empty, rx_full, rx_empty;

  logic out_valid_q;
  logic ok_q, ok_d;
  logic over_q, over_d;
  logic tx_sel_q, tx_sel_d;
  logic rx_sel_q, rx_sel_d;
  logic irq_q, irq_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign tx_full  = (tx_fill == CNT_FULL);
  assign tx_empty = (tx_fill == '0);
  assign rx_full  = (rx_fill == CNT_FULL);
  assign rx_empty = (rx_fill == '0);

  always_comb begin
    tx_cmd   = '0;
    rx_cmd   = '0;
    ok_d     = 1'b0;
    over_d   = 1'b0;
    tx_sel_d = 1'b0;
    rx_sel_d = 1'b0;
    irq_d    = irq_q;
    if (accept) begin
      unique case (utrb_pkg::kind_e'(kind_i))
        utrb_pkg::KIND_PUT_TX: begin
          if (!tx_full) begin
            tx_cmd.push = 1'b1;
            irq_d       = 1'b1;
            ok_d        = 1'b1;
          end
        end
        utrb_pkg::KIND_GET_RX: begin
          if (!rx_empty) begin
            rx_cmd.pop = 1'b1;
            rx_sel_d   = 1'b1;
            ok_d       = 1'b1;
          end
        end
        utrb_pkg::KIND_TX_READY: begin
          if (!tx_empty) begin
            tx_cmd.pop = 1'b1;
            tx_sel_d   = 1'b1;
            ok_d       = 1'b1;
          end else begin
            irq_d = 1'b0;  // nothing left to send
          end
        end
        utrb_pkg::KIND_RX_BYTE: begin
          rx_cmd.push = 1'b1;
          over_d      = rx_full;
          ok_d        = 1'b1;
        end
        utrb_pkg::KIND_FLUSH_RX: begin
          rx_cmd.clear = 1'b1;
          ok_d         = 1'b1;
        end
        utrb_pkg::KIND_FLUSH_TX: begin
          tx_cmd.clear = 1'b1;
          ok_d         = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  utrb_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_tx_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (tx_cmd),
    .wr_data_i (data_in_i),
    .fill_o    (tx_fill),
    .rd_data_o (tx_rd_data)
  );

  utrb_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_rx_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (rx_cmd),
    .wr_data_i (data_in_i),
    .fill_o    (rx_fill),
    .rd_data_o (rx_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      irq_q       <= 1'b0;
    end else begin
      irq_q <= irq_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q     <= ok_d;
      over_q   <= over_d;
      tx_sel_q <= tx_sel_d;
      rx_sel_q <= rx_sel_d;
    end
  end

  // Levels and enable change only on an accepted item, so the live
  // registers already hold the after-item values for the pending result.
  assign out_valid_o     = out_valid_q;
  assign ok_o            = ok_q;
  assign overwrote_o     = over_q;
  assign data_out_o      = rx_sel_q ? rx_rd_data :
                           tx_sel_q ? tx_rd_data : '0;
  assign tx_level_o      = tx_fill;
  assign rx_level_o      = rx_fill;
  assign tx_irq_enable_o = irq_q;

  a_put_sets_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (kind_i == utrb_pkg::KIND_PUT_TX) && !tx_full
      |=> tx_irq_enable_o && ok_o)
    else $error("accepted put did not set irq enable");

  a_overwrite_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (kind_i == utrb_pkg::KIND_RX_BYTE) && rx_full
      |=> overwrote_o && (rx_level_o == CNT_FULL))
    else $error("overwrite into full rx ring misreported");

  a_one_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(tx_sel_q && rx_sel_q) && (!(tx_sel_q || rx_sel_q) || ok_q))
    else $error("data select inconsistent with result");

endmodule

`default_nettype wire

// ===== rtl/core/utrb_ring.sv =====
`default_nettype none

module utrb_ring #(
  parameter int unsigned RING_DEPTH = utrb_pkg::RING_DEPTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire utrb_pkg::ring_cmd_t                cmd_i,
  input  wire logic [utrb_pkg::BYTE_W-1:0]        wr_data_i,
  output logic      [$clog2(RING_DEPTH+1)-1:0]    fill_o,
  output logic      [utrb_pkg::BYTE_W-1:0]        rd_data_o
);

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

  logic [utrb_pkg::BYTE_W-1:0] mem_q [RING_DEPTH];
  logic [utrb_pkg::BYTE_W-1:0] rd_data_q;
  logic [PTR_W-1:0]            rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]            wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]            fill_q, fill_d;
  logic                        full;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign full = (fill_q == CNT_FULL);

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    fill_d   = fill_q;
    if (cmd_i.clear) begin
      rd_ptr_d = '0;
      wr_ptr_d = '0;
      fill_d   = '0;
    end else if (cmd_i.push) begin
      wr_ptr_d = ptr_inc(wr_ptr_q);
      if (full) begin
        rd_ptr_d = ptr_inc(rd_ptr_q);  // oldest entry overwritten
      end else begin
        fill_d = fill_q + CNT_W'(1);
      end
    end else if (cmd_i.pop) begin
      rd_ptr_d = ptr_inc(rd_ptr_q);
      fill_d   = fill_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
    if (cmd_i.pop) begin
      rd_data_q <= mem_q[rd_ptr_q];
    end
  end

  assign fill_o    = fill_q;
  assign rd_data_o = rd_data_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_FULL)
    else $error("ring fill above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> fill_q != '0)
    else $error("pop from empty ring");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (fill_q == '0) && (rd_ptr_q == wr_ptr_q))
    else $error("ring not empty after clear");

endmodule

`default_nettype wire

// ===== dv/tb_uart_tx_rx_ring_buffers.sv =====
`default_nettype none

module tb_uart_tx_rx_ring_buffers;

  localparam int unsigned DEPTH     = utrb_pkg::RING_DEPTH_DEF;
  localparam int unsigned LVL_W     = $clog2(DEPTH + 1);
  localparam int unsigned KIND_W    = utrb_pkg::KIND_W;
  localparam int unsigned BYTE_W    = utrb_pkg::BYTE_W;
  localparam int unsigned IDLE_MAX  = 2000;
  localparam int unsigned HOLD_LEN  = 60;
  localparam int unsigned PHASE_LEN = 220;

  typedef struct packed {
    logic             ok;
    logic [7:0]       data_out;
    logic             overwrote;
    logic [LVL_W-1:0] tx_level;
    logic [LVL_W-1:0] rx_level;
    logic             tx_irq;
  } ring_result_t;

  class ring_result_board;
    logic [7:0]   tx_ring [DEPTH];
    logic [7:0]   rx_ring [DEPTH];
    int unsigned  tx_rd, tx_wr, tx_cnt;
    int unsigned  rx_rd, rx_wr, rx_cnt;
    bit           irq_on;
    ring_result_t pending_results [$];
    int unsigned  mismatches;

    function int unsigned wrap(int unsigned pos);
      return (pos + 1 >= DEPTH) ? 0 : pos + 1;
    endfunction

    // Advance the ring state by one accepted item and queue its result
    function void predict_item(logic [KIND_W-1:0] kind, logic [7:0] data);
      ring_result_t r;
      r = '0;
      case (kind)
        utrb_pkg::KIND_PUT_TX: begin
          if (tx_cnt < DEPTH) begin
            tx_ring[tx_wr] = data;
            tx_wr = wrap(tx_wr);
            tx_cnt++;
            irq_on = 1'b1;
            r.ok = 1'b1;
          end
        end
        utrb_pkg::KIND_GET_RX: begin
          if (rx_cnt > 0) begin
            r.data_out = rx_ring[rx_rd];
            rx_rd = wrap(rx_rd);
            rx_cnt--;
            r.ok = 1'b1;
          end
        end
        utrb_pkg::KIND_TX_READY: begin
          if (tx_cnt > 0) begin
            r.data_out = tx_ring[tx_rd];
            tx_rd = wrap(tx_rd);
            tx_cnt--;
            r.ok = 1'b1;
          end else begin
            irq_on = 1'b0;
          end
        end
        utrb_pkg::KIND_RX_BYTE: begin
          rx_ring[rx_wr] = data;
          rx_wr = wrap(rx_wr);
          if (rx_cnt < DEPTH) begin
            rx_cnt++;
          end else begin
            // full: newest byte replaces oldest unread one
            rx_rd = wrap(rx_rd);
            r.overwrote = 1'b1;
          end
          r.ok = 1'b1;
        end
        utrb_pkg::KIND_FLUSH_RX: begin
          rx_rd = 0;
          rx_wr = 0;
          rx_cnt = 0;
          r.ok = 1'b1;
        end
        utrb_pkg::KIND_FLUSH_TX: begin
          tx_rd = 0;
          tx_wr = 0;
          tx_cnt = 0;
          r.ok = 1'b1;
        end
        default: begin
        end
      endcase
      r.tx_level = LVL_W'(tx_cnt);
      r.rx_level = LVL_W'(rx_cnt);
      r.tx_irq   = irq_on;
      pending_results.push_back(r);
    endfunction

    function void check_result(ring_result_t got);
      ring_result_t exp;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: ok=%0b data=%h ovr=%0b txl=%0d rxl=%0d irq=%0b",
                   got.ok, got.data_out, got.overwrote, got.tx_level, got.rx_level,
                   got.tx_irq);
        return;
      end
      exp = pending_results.pop_front();
      if ((got.ok !== exp.ok) || (got.data_out !== exp.data_out) ||
          (got.overwrote !== exp.overwrote) || (got.tx_level !== exp.tx_level) ||
          (got.rx_level !== exp.rx_level) || (got.tx_irq !== exp.tx_irq)) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp ok=%0b data=%h ovr=%0b txl=%0d rxl=%0d irq=%0b",
                   exp.ok, exp.data_out, exp.overwrote, exp.tx_level, exp.rx_level,
                   exp.tx_irq);
          $display("         got ok=%0b data=%h ovr=%0b txl=%0d rxl=%0d irq=%0b",
                   got.ok, got.data_out, got.overwrote, got.tx_level, got.rx_level,
                   got.tx_irq);
        end
      end
    endfunction

    function int unsigned pending_count();
      return pending_results.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [KIND_W-1:0] kind_i = '0;
  logic [BYTE_W-1:0] data_in_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              ok_o;
  logic [BYTE_W-1:0] data_out_o;
  logic              overwrote_o;
  logic [LVL_W-1:0]  tx_level_o;
  logic [LVL_W-1:0]  rx_level_o;
  logic              tx_irq_enable_o;

  ring_result_board sb;
  ring_result_t     seen;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  bit               hold_req = 1'b0;
  int unsigned      hold_left = 0;
  int unsigned      quiet_cycles = 0;

  uart_tx_rx_ring_buffers dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .data_in_i      (data_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ok_o           (ok_o),
    .data_out_o     (data_out_o),
    .overwrote_o    (overwrote_o),
    .tx_level_o     (tx_level_o),
    .rx_level_o     (rx_level_o),
    .tx_irq_enable_o(tx_irq_enable_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= HOLD_LEN - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.ok        = ok_o;
      seen.data_out  = data_out_o;
      seen.overwrote = overwrote_o;
      seen.tx_level  = tx_level_o;
      seen.rx_level  = rx_level_o;
      seen.tx_irq    = tx_irq_enable_o;
      sb.check_result(seen);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    kind_i <= kind;
    data_in_i <= data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.predict_item(kind, data);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
  endtask

  // fill_bias leans toward puts and received bytes, otherwise toward pops
  function automatic logic [KIND_W-1:0] pick_kind(bit fill_bias);
    int unsigned r;
    r = $urandom_range(99);
    if (fill_bias) begin
      if (r < 35) return utrb_pkg::KIND_PUT_TX;
      if (r < 45) return utrb_pkg::KIND_GET_RX;
      if (r < 55) return utrb_pkg::KIND_TX_READY;
      if (r < 90) return utrb_pkg::KIND_RX_BYTE;
    end else begin
      if (r < 10) return utrb_pkg::KIND_PUT_TX;
      if (r < 45) return utrb_pkg::KIND_GET_RX;
      if (r < 80) return utrb_pkg::KIND_TX_READY;
      if (r < 90) return utrb_pkg::KIND_RX_BYTE;
    end
    if (r < 93) return utrb_pkg::KIND_FLUSH_RX;
    if (r < 96) return utrb_pkg::KIND_FLUSH_TX;
    return KIND_W'($urandom_range(7, 6));
  endfunction

  initial begin
    logic [KIND_W-1:0] k;
    bit                bias;
    int unsigned       n;

    sb = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty-ring cases, full tx refusal, rx overwrite, flushes, unused kinds
    send_item(utrb_pkg::KIND_GET_RX, 8'hFF);
    send_item(utrb_pkg::KIND_TX_READY, 8'hFF);
    send_item(utrb_pkg::KIND_PUT_TX, 8'h00);
    send_item(utrb_pkg::KIND_PUT_TX, 8'hFF);
    send_item(utrb_pkg::KIND_PUT_TX, 8'h55);
    send_item(utrb_pkg::KIND_PUT_TX, 8'hAA);
    for (int i = 0; i < 4; i++) send_item(utrb_pkg::KIND_PUT_TX, 8'($urandom));
    send_item(utrb_pkg::KIND_PUT_TX, 8'h5A);
    send_item(utrb_pkg::KIND_TX_READY, 8'hA5);
    send_item(utrb_pkg::KIND_FLUSH_TX, 8'hFF);
    for (int i = 0; i < 9; i++) send_item(utrb_pkg::KIND_RX_BYTE, 8'(8'h80 + i));
    send_item(utrb_pkg::KIND_GET_RX, 8'h00);
    send_item(utrb_pkg::KIND_FLUSH_RX, 8'hFF);
    send_item(KIND_W'(6), 8'hFF);
    send_item(KIND_W'(7), 8'h00);
    drain_results();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      // long receiver hold-off while items keep coming
      if (p == 0 || p == 3) hold_req = 1'b1;
      n = 0;
      bias = 1'b1;
      while (n < PHASE_LEN) begin
        if (n % 30 == 0) bias = 1'($urandom_range(1));
        k = pick_kind(bias);
        send_item(k, 8'($urandom));
        if (k <= utrb_pkg::KIND_FLUSH_TX) n++;
      end
      drain_results();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/utrb_pkg.sv
rtl/core/utrb_ring.sv
rtl/core/uart_tx_rx_ring_buffers.sv
dv/tb_uart_tx_rx_ring_buffers.sv
